FILE: rtl/mpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the perfect-maze checker.
// No dependencies; used by every module of the block but mpc_ram.
package mpc_pkg;

  localparam int MAX_ROWS_DEF    = 64;
  localparam int MAX_COLUMNS_DEF = 64;
  localparam int STACK_DEPTH_DEF = 16384;

  localparam int COUNT_W     = 7;
  localparam int CFG_INDEX_W = 1;
  localparam int VERDICT_W   = 2;
  localparam int VISIT_W     = 13;

  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 1'b1;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_PERFECT     = 2'd0,
    VERDICT_LOOP        = 2'd1,
    VERDICT_UNREACHABLE = 2'd2
  } verdict_t;

  typedef struct packed {
    logic load;
    logic walk_start;
    logic pop;
    logic fetch;
    logic vread;
    logic mark;
    logic nread;
    logic ntest;
    logic set_loop;
    logic result_load;
  } cmd_t;

  typedef struct packed {
    logic last_cell;
    logic stack_empty;
    logic cell_seen;
    logic nb_last;
    logic out_full;
  } status_t;

endpackage

FILE: rtl/mpc_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mpc_datapath.sv
`timescale 1ns / 1ps
// Datapath: count registers, wall/visited/stack RAMs, walk registers, result register.
// Depends on mpc_pkg and mpc_ram.
module mpc_datapath #(
  parameter int MAX_ROWS    = mpc_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = mpc_pkg::MAX_COLUMNS_DEF,
  parameter int STACK_DEPTH = mpc_pkg::STACK_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [mpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mpc_pkg::COUNT_W-1:0]       cfg_data,
  input  logic                              right_wall,
  input  logic                              bottom_wall,
  input  logic                              out_ready,
  input  mpc_pkg::cmd_t                     cmd,
  output mpc_pkg::status_t                  status,
  output logic                              out_valid,
  output logic [mpc_pkg::VERDICT_W-1:0]     verdict,
  output logic [mpc_pkg::VISIT_W-1:0]       cells_visited
);

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RNW   = $clog2(MAX_ROWS + 1);
  localparam int CLN   = $clog2(MAX_COLUMNS + 1);
  localparam int CELLS = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int NW    = $clog2(CELLS + 1);
  localparam int SAW   = $clog2(STACK_DEPTH);
  localparam int SPW   = $clog2(STACK_DEPTH + 1);
  localparam int SDW   = RW + CW;

  // count registers, clamped on write
  logic [RNW-1:0] rows;
  logic [CLN-1:0] cols;
  logic [RNW-1:0] row_clamp;
  logic [CLN-1:0] col_clamp;
  logic [NW-1:0]  total;

  always_comb begin
    if (cfg_data == '0) begin
      row_clamp = RNW'(1);
    end else if (32'(cfg_data) > MAX_ROWS) begin
      row_clamp = RNW'(MAX_ROWS);
    end else begin
      row_clamp = RNW'(cfg_data);
    end
    if (cfg_data == '0) begin
      col_clamp = CLN'(1);
    end else if (32'(cfg_data) > MAX_COLUMNS) begin
      col_clamp = CLN'(MAX_COLUMNS);
    end else begin
      col_clamp = CLN'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= RNW'(1);
      cols <= CLN'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        mpc_pkg::REG_ROW_COUNT:    rows <= row_clamp;
        mpc_pkg::REG_COLUMN_COUNT: cols <= col_clamp;
      endcase
    end
  end

  assign total = NW'(rows) * NW'(cols);

  // load counter
  logic [AW-1:0] load_count;
  logic          last_cell;

  assign last_cell = (NW'(load_count) + NW'(1)) >= total;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (cmd.load) begin
      load_count <= last_cell ? '0 : load_count + AW'(1);
    end
  end

  // walk registers
  logic [SPW-1:0] sp;
  logic [SPW-1:0] sp_dec;
  logic [NW-1:0]  visit_count;
  logic           loop_flag;
  logic [1:0]     k;
  logic [RW-1:0]  cur_row;
  logic [CW-1:0]  cur_col;
  logic [AW-1:0]  cur_cell;
  logic           nb_ok;
  logic [RW-1:0]  nb_row;
  logic [CW-1:0]  nb_col;
  logic           wall_sel;

  logic [1:0]     wall_rdata;
  logic           visited_rdata;
  logic [SDW-1:0] stk_rdata;
  logic [AW-1:0]  fetch_cell;
  logic           wall_hit;
  logic           push_now;

  assign sp_dec     = sp - SPW'(1);
  assign fetch_cell = AW'(NW'(stk_rdata[SDW-1:CW]) * NW'(cols) + NW'(stk_rdata[CW-1:0]));
  assign wall_hit   = wall_sel ? wall_rdata[1] : wall_rdata[0];
  assign push_now   = cmd.ntest && nb_ok && !wall_hit && !visited_rdata &&
                      (sp < SPW'(STACK_DEPTH));

  // neighbor of the current cell selected by k: left, up, right, down
  logic          nbk_ok;
  logic [RW-1:0] nbk_row;
  logic [CW-1:0] nbk_col;
  logic [AW-1:0] nbk_addr;
  logic [AW-1:0] wk_addr;
  logic          wk_sel;

  always_comb begin
    nbk_ok   = 1'b0;
    nbk_row  = cur_row;
    nbk_col  = cur_col;
    nbk_addr = cur_cell;
    wk_addr  = cur_cell;
    wk_sel   = 1'b0;
    case (k)
      2'd0: begin
        nbk_ok   = cur_col != '0;
        nbk_col  = cur_col - CW'(1);
        nbk_addr = cur_cell - AW'(1);
        wk_addr  = cur_cell - AW'(1);
      end
      2'd1: begin
        nbk_ok   = cur_row != '0;
        nbk_row  = cur_row - RW'(1);
        nbk_addr = cur_cell - AW'(cols);
        wk_addr  = cur_cell - AW'(cols);
        wk_sel   = 1'b1;
      end
      2'd2: begin
        nbk_ok   = (CLN'(cur_col) + CLN'(1)) < cols;
        nbk_col  = cur_col + CW'(1);
        nbk_addr = cur_cell + AW'(1);
      end
      2'd3: begin
        nbk_ok   = (RNW'(cur_row) + RNW'(1)) < rows;
        nbk_row  = cur_row + RW'(1);
        nbk_addr = cur_cell + AW'(cols);
        wk_sel   = 1'b1;
      end
    endcase
    if (!nbk_ok) begin
      nbk_addr = cur_cell;
      wk_addr  = cur_cell;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp          <= '0;
      visit_count <= '0;
      loop_flag   <= 1'b0;
      k           <= '0;
    end else begin
      if (cmd.walk_start) begin
        sp <= SPW'(1);
      end else if (cmd.pop) begin
        sp <= sp_dec;
      end else if (push_now) begin
        sp <= sp + SPW'(1);
      end
      if (cmd.walk_start) begin
        visit_count <= '0;
      end else if (cmd.mark) begin
        visit_count <= visit_count + NW'(1);
      end
      if (cmd.walk_start) begin
        loop_flag <= 1'b0;
      end else if (cmd.set_loop) begin
        loop_flag <= 1'b1;
      end
      if (cmd.mark) begin
        k <= '0;
      end else if (cmd.ntest) begin
        k <= k + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      cur_row  <= stk_rdata[SDW-1:CW];
      cur_col  <= stk_rdata[CW-1:0];
      cur_cell <= fetch_cell;
    end
    if (cmd.nread) begin
      nb_ok    <= nbk_ok;
      nb_row   <= nbk_row;
      nb_col   <= nbk_col;
      wall_sel <= wk_sel;
    end
  end

  // storage
  mpc_ram #(.WIDTH(2), .DEPTH(CELLS)) u_wall_ram (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (load_count),
    .wdata ({bottom_wall, right_wall}),
    .raddr (wk_addr),
    .rdata (wall_rdata)
  );

  mpc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited_ram (
    .clk   (clk),
    .we    (cmd.load | cmd.mark),
    .waddr (cmd.load ? load_count : cur_cell),
    .wdata (cmd.mark),
    .raddr (cmd.vread ? cur_cell : nbk_addr),
    .rdata (visited_rdata)
  );

  mpc_ram #(.WIDTH(SDW), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (cmd.walk_start | push_now),
    .waddr (cmd.walk_start ? '0 : sp[SAW-1:0]),
    .wdata (cmd.walk_start ? '0 : {nb_row, nb_col}),
    .raddr (sp_dec[SAW-1:0]),
    .rdata (stk_rdata)
  );

  // result register
  mpc_pkg::verdict_t verdict_next;

  always_comb begin
    if (loop_flag) begin
      verdict_next = mpc_pkg::VERDICT_LOOP;
    end else if (visit_count != total) begin
      verdict_next = mpc_pkg::VERDICT_UNREACHABLE;
    end else begin
      verdict_next = mpc_pkg::VERDICT_PERFECT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      verdict       <= verdict_next;
      cells_visited <= mpc_pkg::VISIT_W'(visit_count);
    end
  end

  assign status.last_cell   = last_cell;
  assign status.stack_empty = sp == '0;
  assign status.cell_seen   = visited_rdata;
  assign status.nb_last     = k == 2'd3;
  assign status.out_full    = out_valid;

endmodule

FILE: rtl/mpc_controller.sv
`timescale 1ns / 1ps
// Controller state machine: load phase, depth-first walk sequencing, result hand-off.
// Depends on mpc_pkg.
module mpc_controller (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_ready,
  input  mpc_pkg::status_t status,
  output logic             in_ready,
  output mpc_pkg::cmd_t    cmd
);

  typedef enum logic [8:0] {
    ST_LOAD   = 9'b0_0000_0001,
    ST_START  = 9'b0_0000_0010,
    ST_POP    = 9'b0_0000_0100,
    ST_FETCH  = 9'b0_0000_1000,
    ST_VREAD  = 9'b0_0001_0000,
    ST_VTEST  = 9'b0_0010_0000,
    ST_NREAD  = 9'b0_0100_0000,
    ST_NTEST  = 9'b0_1000_0000,
    ST_FINISH = 9'b1_0000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        if (in_valid && status.last_cell) begin
          state_next = ST_START;
        end
      end
      ST_START: begin
        cmd.walk_start = 1'b1;
        state_next     = ST_POP;
      end
      ST_POP: begin
        if (status.stack_empty) begin
          state_next = ST_FINISH;
        end else begin
          cmd.pop    = 1'b1;
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = ST_VREAD;
      end
      ST_VREAD: begin
        cmd.vread  = 1'b1;
        state_next = ST_VTEST;
      end
      ST_VTEST: begin
        if (status.cell_seen) begin
          cmd.set_loop = 1'b1;
          state_next   = ST_FINISH;
        end else begin
          cmd.mark   = 1'b1;
          state_next = ST_NREAD;
        end
      end
      ST_NREAD: begin
        cmd.nread  = 1'b1;
        state_next = ST_NTEST;
      end
      ST_NTEST: begin
        cmd.ntest  = 1'b1;
        state_next = status.nb_last ? ST_POP : ST_NREAD;
      end
      ST_FINISH: begin
        if (!status.out_full || out_ready) begin
          cmd.result_load = 1'b1;
          state_next      = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

endmodule

FILE: rtl/perfect_maze_checker_top.sv
`timescale 1ns / 1ps
// Top level of the perfect-maze checker: controller plus datapath.
// Depends on mpc_pkg, mpc_controller, mpc_datapath (and mpc_ram inside it).
//
// Channel | Direction | Handshake                 | Payload
// cfg     | in        | cfg_write (no wait)       | cfg_index, cfg_data
// in      | in        | in_valid / in_ready       | right_wall, bottom_wall
// out     | out       | out_valid / out_ready     | verdict, cells_visited
//
// Loading takes one cell per cycle; a transaction that completes the grid starts the walk.
// The walk handles each visited cell in steps (pop, fetch, visited check, then a
// read and a test per neighbor through the single read port of each RAM);
// a repeated cell ends the walk.
// Reset is synchronous; the visited map is cleared cell by cell while loading,
// so no clearing pass follows reset. Loading continues while a result waits;
// a finished walk holds until the output register is free.
module perfect_maze_checker_top #(
  parameter int MAX_ROWS    = mpc_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = mpc_pkg::MAX_COLUMNS_DEF,
  parameter int STACK_DEPTH = mpc_pkg::STACK_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [mpc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mpc_pkg::COUNT_W-1:0]       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              right_wall,
  input  logic                              bottom_wall,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mpc_pkg::VERDICT_W-1:0]     verdict,
  output logic [mpc_pkg::VISIT_W-1:0]       cells_visited
);

  mpc_pkg::cmd_t    cmd;
  mpc_pkg::status_t status;

  mpc_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_ready (out_ready),
    .status    (status),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  mpc_datapath #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .right_wall    (right_wall),
    .bottom_wall   (bottom_wall),
    .out_ready     (out_ready),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .verdict       (verdict),
    .cells_visited (cells_visited)
  );

endmodule

FILE: rtl/mpc_checker.sv
`timescale 1ns / 1ps
// Port-level assertions for the perfect-maze checker, bound to the top level.
// Depends on mpc_pkg for field widths.
module mpc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [mpc_pkg::VERDICT_W-1:0]     verdict,
  input logic [mpc_pkg::VISIT_W-1:0]       cells_visited
);

  // reset leaves no result and an open input
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  a_reset_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

  // a new result only comes from a walk, never in the cycle after a load transaction
  a_result_from_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared straight from the load phase");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(cells_visited))
    else $error("stalled result changed");

endmodule

bind perfect_maze_checker_top mpc_checker u_mpc_checker (.*);
